// File: src/pdi_pkg.sv
// Shared types and constants for the pair deduplication indexer.
// Used by pdi_cell and pair_dedup_indexer; depends on nothing.
`default_nettype none

package pdi_pkg;

  // Number of table entries, one per cell of the chain
  localparam int TABLE_DEPTH = 256;
  // Width of node values and of the assigned index
  localparam int DATA_W = 32;

  // Numbering modes of the configuration register
  localparam logic MODE_ROW     = 1'b0;
  localparam logic MODE_COMPACT = 1'b1;

  // Lookup token that travels down the chain, one cell per cycle unless the chain is stalled
  typedef struct packed {
    logic              live;    // token carries an item
    logic [DATA_W-1:0] lo;      // sorted pair, smaller value
    logic [DATA_W-1:0] hi;      // sorted pair, larger value
    logic [DATA_W-1:0] idx;     // fresh index, replaced by stored index on a hit
    logic              done;    // a cell has matched or stored the pair
    logic              is_new;  // pair was not found in the table
  } token_t;

endpackage

`default_nettype wire

// File: src/pdi_cell.sv
// One table entry of the deduplication chain: stored pair, index and valid bit.
// Compares the passing token, stores it in the first empty cell. Uses pdi_pkg.
`default_nettype none

module pdi_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            clear,
  input  pdi_pkg::token_t      tok_i,
  output pdi_pkg::token_t      tok_o
);
  import pdi_pkg::*;

  logic                valid_r;
  logic [2*DATA_W-1:0] key_r;
  logic [DATA_W-1:0]   index_r;
  token_t              tok_r;
  token_t              tok_nxt;

  logic vld_eff;
  logic pending;
  logic hit;
  logic ins;

  // Compare against the entry; a clear in the same cycle empties it first
  always_comb begin
    vld_eff = valid_r & ~clear;
    pending = tok_i.live & ~tok_i.done;
    hit     = pending & vld_eff & (key_r == {tok_i.lo, tok_i.hi});
    ins     = pending & ~vld_eff;
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.is_new = 1'b0;
      tok_nxt.idx    = index_r;
    end else if (ins) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.is_new = 1'b1;
    end
  end

  // Hold the entry valid bit; drop it on a new matrix unless refilled at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en && ins) begin
      valid_r <= 1'b1;
    end else if (clear) begin
      valid_r <= 1'b0;
    end
  end

  // Store a new pair with its index
  always_ff @(posedge clk) begin
    if (en && ins) begin
      key_r   <= {tok_i.lo, tok_i.hi};
      index_r <= tok_i.idx;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// File: src/pair_dedup_indexer.sv
// Top level of the unordered pair deduplication table: sorter, counters,
// chain of pdi_cell entries and output register. Uses pdi_pkg and pdi_cell.
//
//   channel   ports                                       direction
//   input     in_valid/in_ready, in_first_row,            in
//             in_value_a, in_value_b
//   result    out_valid/out_ready, out_low_value,         out
//             out_high_value, out_assigned_index,
//             out_is_new, out_table_overflow
//   config    cfg_wr_en, cfg_wr_data (numbering mode)     in
//
// One item at a time: a transfer enters cell 0 and its token walks the
// TABLE_DEPTH cells, one per cycle while the chain is not stalled; the
// result is registered in the output register as the token leaves the last
// cell, and the next item is taken once the token has left the chain.
// Synchronous active-low reset empties the table, zeroes both counters and
// sets compact numbering. A stalled result holds the whole chain while the
// next token waits at the last cell.
`default_nettype none

module pair_dedup_indexer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_wr_data,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_first_row,
  input  wire logic [pdi_pkg::DATA_W-1:0] in_value_a,
  input  wire logic [pdi_pkg::DATA_W-1:0] in_value_b,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [pdi_pkg::DATA_W-1:0]      out_low_value,
  output logic [pdi_pkg::DATA_W-1:0]      out_high_value,
  output logic [pdi_pkg::DATA_W-1:0]      out_assigned_index,
  output logic                            out_is_new,
  output logic                            out_table_overflow
);
  import pdi_pkg::*;

  logic              mode_r;
  logic              busy_r;
  logic [DATA_W-1:0] row_r;
  logic [DATA_W-1:0] unique_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_lo_r;
  logic [DATA_W-1:0] out_hi_r;
  logic [DATA_W-1:0] out_idx_r;
  logic              out_new_r;
  logic              out_ovf_r;

  logic              in_fire;
  logic              clear;
  logic              en;
  logic              exit_fire;
  logic              exit_new;
  logic [DATA_W-1:0] row_cur;
  logic [DATA_W-1:0] unique_cur;
  token_t            entry_tok;
  token_t            last_tok;
  token_t            chain_w [TABLE_DEPTH+1];

  assign in_ready = ~busy_r;
  assign in_fire  = in_valid & in_ready;
  assign clear    = in_fire & in_first_row;

  // Stall the chain only while a token at the last cell meets a result not yet taken
  assign last_tok  = chain_w[TABLE_DEPTH];
  assign en        = ~(last_tok.live & out_valid_r & ~out_ready);
  assign exit_fire = last_tok.live & en;
  assign exit_new  = ~last_tok.done | last_tok.is_new;

  // Sort the pair and pick the fresh index
  always_comb begin
    row_cur    = in_first_row ? '0 : row_r;
    unique_cur = in_first_row ? '0 : unique_r;
    entry_tok        = '0;
    entry_tok.live   = in_fire;
    entry_tok.lo     = (in_value_a < in_value_b) ? in_value_a : in_value_b;
    entry_tok.hi     = (in_value_a < in_value_b) ? in_value_b : in_value_a;
    entry_tok.idx    = (mode_r == MODE_COMPACT) ? unique_cur : row_cur;
    entry_tok.done   = 1'b0;
    entry_tok.is_new = 1'b1;
  end

  assign chain_w[0] = entry_tok;

  // Chain of table cells
  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    pdi_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .clear (clear),
      .tok_i (chain_w[gi]),
      .tok_o (chain_w[gi+1])
    );
  end

  // Hold the numbering mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COMPACT;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Track the item in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (exit_fire) begin
      busy_r <= 1'b0;
    end
  end

  // Advance row and unique counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      unique_r <= '0;
    end else begin
      if (in_fire) begin
        row_r <= row_cur + DATA_W'(1);
      end
      if (clear) begin
        unique_r <= '0;
      end else if (exit_fire && exit_new) begin
        unique_r <= unique_r + DATA_W'(1);
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result leaving the chain
  always_ff @(posedge clk) begin
    if (exit_fire) begin
      out_lo_r  <= last_tok.lo;
      out_hi_r  <= last_tok.hi;
      out_idx_r <= last_tok.idx;
      out_new_r <= exit_new;
      out_ovf_r <= ~last_tok.done;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_low_value      = out_lo_r;
  assign out_high_value     = out_hi_r;
  assign out_assigned_index = out_idx_r;
  assign out_is_new         = out_new_r;
  assign out_table_overflow = out_ovf_r;

endmodule

`default_nettype wire
